### rtl/button_press_pattern_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Button press pattern decoder: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_PATTERN_DECODER_TOP_DEFINES_SVH
`define BUTTON_PRESS_PATTERN_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BPPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bppd check failed: same-cycle implication");

// Next-cycle implication.
`define BPPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bppd check failed: next-cycle implication");

`endif

### rtl/bppd_pkg.sv
// ----------------------------------------------------------------------------
// bppd_pkg
// Payload types and fixed codes of the button press pattern decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bppd_pkg;

  localparam int unsigned CfgW = 24;

  // Configuration register indexes
  localparam logic CFG_LONG_WINDOW  = 1'b0;
  localparam logic CFG_SHORT_WINDOW = 1'b1;

  // Request kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Button levels
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  // Event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_LONG       = 3'd1;
  localparam logic [2:0] EV_SHORT      = 3'd2;
  localparam logic [2:0] EV_SHORT_LONG = 3'd3;
  localparam logic [2:0] EV_DOUBLE     = 3'd4;
  localparam logic [2:0] EV_TRIPLE     = 3'd5;
  localparam logic [2:0] EV_FOUR_LONG  = 3'd6;

  typedef struct packed {
    logic req_type;
    logic level;
  } in_req_t;

  typedef struct packed {
    logic       event_valid;
    logic [2:0] event_code;
    logic       buzzer_on;
    logic       pwr_state;
  } out_rsp_t;

endpackage

`default_nettype wire

### rtl/button_press_pattern_decoder_top.sv
// ----------------------------------------------------------------------------
// Button press pattern decoder
// Counts presses and releases of a button inside a timed window and reports
// the gesture as an event code when the window runs out.
// ----------------------------------------------------------------------------
// Each input transfer is a button edge or one timer tick, and each one yields
// exactly one output transfer carrying the event flag and code, the buzzer
// drive and the power flag. An item is registered on input, processed by a
// single pass of counter/compare logic against the gesture state, and
// registered on output, one item per clock sustained while the output is not
// stalled. Throughput is set by the output register: while it holds an
// undelivered result that is stalled, the input stage holds too and
// in_stall_o rises once that stage is full. Window registers are to be
// written through the cfg port only while no item is in flight; the block
// does not enforce it. A zero window acts as one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_pattern_decoder_top #(
  parameter int unsigned TIMER_BITS = 24,
  parameter int unsigned COUNT_MAX  = 15
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // config write port
  input  wire                           cfg_we_i,
  input  wire                           cfg_idx_i,
  input  wire  [bppd_pkg::CfgW-1:0]     cfg_wdata_i,
  // request channel
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  bppd_pkg::in_req_t             in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output bppd_pkg::out_rsp_t            out_data_o
);

  localparam int unsigned CountW = $clog2(COUNT_MAX + 1);
  localparam logic [CountW-1:0] CountSat = CountW'(COUNT_MAX);

  // window registers
  logic [bppd_pkg::CfgW-1:0] long_win_q, short_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_win_q  <= bppd_pkg::CfgW'(1000);
      short_win_q <= bppd_pkg::CfgW'(400);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bppd_pkg::CFG_LONG_WINDOW:  long_win_q  <= cfg_wdata_i;
        bppd_pkg::CFG_SHORT_WINDOW: short_win_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control: advance when the output register is free or draining
  logic              advance;
  logic              s1_valid_q;
  bppd_pkg::in_req_t s1_data_q;
  logic              out_valid_q;
  bppd_pkg::out_rsp_t out_data_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // gesture state
  logic                  active_q, active_d;
  logic [CountW-1:0]     press_q, press_d;
  logic [CountW-1:0]     rel_q, rel_d;
  logic [TIMER_BITS-1:0] cd_q, cd_d;
  logic                  buzz_q, buzz_d;
  logic                  power_q, power_d;
  logic                  ev_valid;
  logic [2:0]            ev_code;
  logic [2:0]            decoded;
  logic [CountW-1:0]     press_inc;

  // pattern table on (releases, presses)
  always_comb begin
    decoded = bppd_pkg::EV_NONE;
    if      (rel_q == CountW'(0) && press_q == CountW'(1)) decoded = bppd_pkg::EV_LONG;
    else if (rel_q == CountW'(1) && press_q == CountW'(1)) decoded = bppd_pkg::EV_SHORT;
    else if (rel_q == CountW'(1) && press_q == CountW'(2)) decoded = bppd_pkg::EV_SHORT_LONG;
    else if (rel_q == CountW'(2) && press_q == CountW'(2)) decoded = bppd_pkg::EV_DOUBLE;
    else if (rel_q == CountW'(3) && press_q == CountW'(3)) decoded = bppd_pkg::EV_TRIPLE;
    else if (rel_q == CountW'(4) && press_q == CountW'(5)) decoded = bppd_pkg::EV_FOUR_LONG;
  end

  assign press_inc = (press_q >= CountSat) ? CountSat : press_q + CountW'(1);

  always_comb begin
    active_d = active_q;
    press_d  = press_q;
    rel_d    = rel_q;
    cd_d     = cd_q;
    buzz_d   = buzz_q;
    power_d  = power_q;
    ev_valid = 1'b0;
    ev_code  = bppd_pkg::EV_NONE;

    if (s1_data_q.req_type == bppd_pkg::REQ_EDGE) begin
      if (s1_data_q.level == bppd_pkg::LVL_PRESSED) begin
        press_d = press_inc;
        buzz_d  = 1'b1;
      end
      if (press_d == '0) begin
        // release with no press seen: drop it, window untouched
        rel_d = '0;
      end else begin
        if (s1_data_q.level == bppd_pkg::LVL_RELEASED) begin
          rel_d  = (rel_q >= CountSat) ? CountSat : rel_q + CountW'(1);
          buzz_d = 1'b0;
        end
        if (!active_q) begin
          active_d = 1'b1;
          cd_d     = TIMER_BITS'(long_win_q);
        end else begin
          cd_d     = TIMER_BITS'(short_win_q);
        end
      end
    end else if (active_q) begin
      if (cd_q > TIMER_BITS'(1)) begin
        cd_d = cd_q - TIMER_BITS'(1);
      end else begin
        // window expired (zero counts as one)
        ev_valid = 1'b1;
        ev_code  = decoded;
        buzz_d   = 1'b0;
        press_d  = '0;
        rel_d    = '0;
        active_d = 1'b0;
        cd_d     = '0;
        if (decoded == bppd_pkg::EV_LONG) begin
          power_d = !power_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      press_q  <= '0;
      rel_q    <= '0;
      cd_q     <= '0;
      buzz_q   <= 1'b0;
      power_q  <= 1'b1;
    end else if (advance && s1_valid_q) begin
      active_q <= active_d;
      press_q  <= press_d;
      rel_q    <= rel_d;
      cd_q     <= cd_d;
      buzz_q   <= buzz_d;
      power_q  <= power_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q.event_valid <= ev_valid;
      out_data_q.event_code  <= ev_code;
      out_data_q.buzzer_on   <= buzz_d;
      out_data_q.pwr_state   <= power_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/bppd_checker.sv
// ----------------------------------------------------------------------------
// bppd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_pattern_decoder_top_defines.svh"

module bppd_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_i,
  input wire                out_stall_i,
  input bppd_pkg::out_rsp_t out_data_i
);

  // stalled result holds
  `BPPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
                   out_valid_i && $stable(out_data_i))

  // no code without an expiry
  `BPPD_ASSERT_IMP(a_code_needs_event, clk_i, rst_ni,
                   out_valid_i && !out_data_i.event_valid,
                   out_data_i.event_code == bppd_pkg::EV_NONE)

  // expiry always silences the buzzer
  `BPPD_ASSERT_IMP(a_expiry_buzz_off, clk_i, rst_ni,
                   out_valid_i && out_data_i.event_valid, !out_data_i.buzzer_on)

endmodule

bind button_press_pattern_decoder_top bppd_checker u_bppd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

### tb/sv/bppd_event_checker.sv
// ----------------------------------------------------------------------------
// Button press pattern decoder: event checker
// Follows the window registers and every request transfer, predicts the
// result of each one and compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module bppd_event_checker #(
  parameter int unsigned TIMER_BITS = 24,
  parameter int unsigned COUNT_MAX  = 15
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire                        cfg_idx_i,
  input  wire  [bppd_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire                        in_valid_i,
  input  wire                        in_stall_i,
  input  bppd_pkg::in_req_t          in_data_i,
  input  wire                        out_valid_i,
  input  wire                        out_stall_i,
  input  bppd_pkg::out_rsp_t         out_data_i,
  output int                         errors_o,
  output int                         pending_o
);

  // Predicted block state
  logic [bppd_pkg::CfgW-1:0] long_win_q;
  logic [bppd_pkg::CfgW-1:0] short_win_q;
  logic                      gesture_q;
  logic [7:0]                press_q;
  logic [7:0]                rel_q;
  logic [TIMER_BITS-1:0]     countdown_q;
  logic                      buzzer_q;
  logic                      power_q;

  bppd_pkg::out_rsp_t rsp_expected_q[$];
  bppd_pkg::out_rsp_t rsp_next;
  bppd_pkg::out_rsp_t rsp_want;
  int                 errors;

  assign errors_o = errors;

  task automatic report_mismatch(string msg);
    $display("%0t: result mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v >= COUNT_MAX) ? 8'(COUNT_MAX) : v + 8'd1;
  endfunction

  function automatic logic [2:0] gesture_code(logic [7:0] rel, logic [7:0] prs);
    if (rel == 8'd0 && prs == 8'd1) return bppd_pkg::EV_LONG;
    if (rel == 8'd1 && prs == 8'd1) return bppd_pkg::EV_SHORT;
    if (rel == 8'd1 && prs == 8'd2) return bppd_pkg::EV_SHORT_LONG;
    if (rel == 8'd2 && prs == 8'd2) return bppd_pkg::EV_DOUBLE;
    if (rel == 8'd3 && prs == 8'd3) return bppd_pkg::EV_TRIPLE;
    if (rel == 8'd4 && prs == 8'd5) return bppd_pkg::EV_FOUR_LONG;
    return bppd_pkg::EV_NONE;
  endfunction

  task automatic step_gesture(input bppd_pkg::in_req_t req, output bppd_pkg::out_rsp_t rsp);
    logic [2:0] code;
    logic       fired;
    code  = bppd_pkg::EV_NONE;
    fired = 1'b0;
    if (req.req_type == bppd_pkg::REQ_EDGE) begin
      if (req.level == bppd_pkg::LVL_PRESSED) begin
        press_q  = sat_inc(press_q);
        buzzer_q = 1'b1;
      end
      if (press_q == 8'd0) begin
        // stray release: only the release count is cleared
        rel_q = 8'd0;
      end else begin
        if (req.level == bppd_pkg::LVL_RELEASED) begin
          rel_q    = sat_inc(rel_q);
          buzzer_q = 1'b0;
        end
        if (!gesture_q) begin
          gesture_q   = 1'b1;
          countdown_q = TIMER_BITS'(long_win_q);
        end else begin
          countdown_q = TIMER_BITS'(short_win_q);
        end
      end
    end else if (gesture_q) begin
      if (countdown_q > 1) begin
        countdown_q = countdown_q - 1'b1;
      end else begin
        code        = gesture_code(rel_q, press_q);
        fired       = 1'b1;
        buzzer_q    = 1'b0;
        press_q     = 8'd0;
        rel_q       = 8'd0;
        gesture_q   = 1'b0;
        countdown_q = '0;
        if (code == bppd_pkg::EV_LONG) power_q = !power_q;
      end
    end
    rsp.event_valid = fired;
    rsp.event_code  = code;
    rsp.buzzer_on   = buzzer_q;
    rsp.pwr_state   = power_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_win_q  = 24'd1000;
      short_win_q = 24'd400;
      gesture_q   = 1'b0;
      press_q     = 8'd0;
      rel_q       = 8'd0;
      countdown_q = '0;
      buzzer_q    = 1'b0;
      power_q     = 1'b1;
      rsp_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bppd_pkg::CFG_LONG_WINDOW) long_win_q = cfg_wdata_i;
        else short_win_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        step_gesture(in_data_i, rsp_next);
        rsp_expected_q.push_back(rsp_next);
      end
      if (out_valid_i && !out_stall_i) begin
        if (rsp_expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          rsp_want = rsp_expected_q.pop_front();
          if (out_data_i.event_valid !== rsp_want.event_valid)
            report_mismatch($sformatf("event_valid %b, want %b",
                                      out_data_i.event_valid, rsp_want.event_valid));
          if (out_data_i.event_code !== rsp_want.event_code)
            report_mismatch($sformatf("event_code %0d, want %0d",
                                      out_data_i.event_code, rsp_want.event_code));
          if (out_data_i.buzzer_on !== rsp_want.buzzer_on)
            report_mismatch($sformatf("buzzer_on %b, want %b",
                                      out_data_i.buzzer_on, rsp_want.buzzer_on));
          if (out_data_i.pwr_state !== rsp_want.pwr_state)
            report_mismatch($sformatf("pwr_state %b, want %b",
                                      out_data_i.pwr_state, rsp_want.pwr_state));
        end
      end
      pending_o <= rsp_expected_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Button press pattern decoder: testbench top
// Drives edges, ticks and window writes into the decoder, with random gaps
// on the request side and random stalls on the result side; the event
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [bppd_pkg::CfgW-1:0] cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  bppd_pkg::in_req_t         in_data;
  logic                      out_valid;
  logic                      out_stall;
  bppd_pkg::out_rsp_t        out_data;

  int errors;
  int pending;

  // calm: no gaps and no stalls while set
  bit calm;
  int sent_items;
  // window lengths as last written, used only to size tick runs
  int long_win;
  int short_win;

  button_press_pattern_decoder_top #(
    .TIMER_BITS(24),
    .COUNT_MAX (15)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  bppd_event_checker #(
    .TIMER_BITS(24),
    .COUNT_MAX (15)
  ) u_event_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stall with probability 9/100, never while calm.
  always @(posedge clk_i) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 9);
  end

  // One request transfer. A random gap may come first; valid then stays up
  // until the transfer happens, with the payload held.
  task automatic send_req(logic req, logic lvl);
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, level: lvl};
    do @(posedge clk_i); while (in_stall);
    sent_items++;
  endtask

  // The level bit is don't-care on a tick, so it is randomized there.
  task automatic send_tick();
    send_req(bppd_pkg::REQ_TICK, 1'($urandom_range(1)));
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_tick();
  endtask

  // Hold off until every expected result has arrived. The pending count
  // is registered, so an edge with valid low always passes first.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Both window registers, written back to back once the block is idle.
  task automatic write_windows(int lw, int sw);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= bppd_pkg::CFG_LONG_WINDOW;
    cfg_wdata <= bppd_pkg::CfgW'(lw);
    @(posedge clk_i);
    cfg_idx   <= bppd_pkg::CFG_SHORT_WINDOW;
    cfg_wdata <= bppd_pkg::CfgW'(sw);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    long_win  = lw;
    short_win = sw;
  endtask

  // One random gesture followed by enough ticks to close its window.
  //  - well formed: alternating press/release for one of the six codes,
  //    gaps kept inside the window so the pattern completes
  //  - noise: random levels and gaps that may run the window out early
  //  - burst: back-to-back press/release pairs past count saturation
  task automatic run_gesture();
    int mode;
    int k;
    int n_edges;
    int hold;
    int max_win;
    mode    = $urandom_range(99);
    max_win = (long_win > short_win) ? long_win : short_win;
    // now and then a release with no press before it
    if ($urandom_range(9) == 0) send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    if (mode < 70) begin
      k = $urandom_range(1, 6);
      case (k)
        1: n_edges = 1;
        2: n_edges = 2;
        3: n_edges = 3;
        4: n_edges = 4;
        5: n_edges = 6;
        default: n_edges = 9;
      endcase
      for (int i = 0; i < n_edges; i++) begin
        send_req(bppd_pkg::REQ_EDGE,
                 (i % 2 == 0) ? bppd_pkg::LVL_PRESSED : bppd_pkg::LVL_RELEASED);
        hold = (i == 0) ? long_win : short_win;
        if (hold < 1) hold = 1;
        if (i < n_edges - 1) send_ticks($urandom_range(0, hold - 1));
      end
    end else if (mode < 85) begin
      n_edges = $urandom_range(1, 12);
      for (int i = 0; i < n_edges; i++) begin
        send_req(bppd_pkg::REQ_EDGE, 1'($urandom_range(1)));
        send_ticks($urandom_range(0, short_win + 2));
      end
    end else begin
      n_edges = $urandom_range(16, 20);
      for (int i = 0; i < n_edges; i++) begin
        send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
        if ($urandom_range(3) != 0) send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
      end
    end
    send_ticks(max_win + 1 + $urandom_range(0, 2));
  endtask

  initial begin
    int phase;
    int lw;
    int sw;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = bppd_pkg::CFG_LONG_WINDOW;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    calm       = 1'b0;
    sent_items = 0;
    long_win   = 1000;
    short_win  = 400;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset windows: idle tick, stray release, then a short press whose
    // release restarts the default short window and runs it out.
    send_tick();
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_ticks(5);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_ticks(410);

    // Small windows: long press, short press, two presses with no release.
    write_windows(3, 2);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_ticks(3);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_tick();
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_ticks(2);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_ticks(3);

    // Zero windows act as one tick.
    write_windows(0, 0);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_tick();
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_tick();

    // Full-scale short window, cut short by a later rewrite.
    write_windows(2, 24'hFFFFFF);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_tick();
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_tick();
    write_windows(2, 1);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_tick();

    // Full-scale long window, closed by the short window of the release.
    write_windows(24'hFFFFFF, 1);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_PRESSED);
    send_ticks(2);
    send_req(bppd_pkg::REQ_EDGE, bppd_pkg::LVL_RELEASED);
    send_tick();

    // Random gestures, a fresh pair of windows per phase; the first phase
    // runs with no gaps and no stalls.
    phase = 0;
    while (sent_items < 650) begin
      lw = (phase % 5 == 4) ? 0 : $urandom_range(1, 12);
      sw = (phase % 7 == 5) ? 0 : $urandom_range(1, 8);
      write_windows(lw, sw);
      calm = (phase == 0);
      for (int g = 0; g < 8 && sent_items < 650; g++) begin
        run_gesture();
        // mid-phase hold-off until the result queue is empty
        if ($urandom_range(9) == 0) drain();
      end
      calm = 1'b0;
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
